/* hdl/crrd_pkg.sv */
// Shared types, constants and helpers for the chart row run-length decoder.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package crrd_pkg;

	localparam int CNT_W = 15;               // run counts, widths, pixel positions
	localparam int COLOR_W = 7;
	localparam int DEPTH_W = 3;
	localparam int ACC_EXT_W = CNT_W + 7;    // accumulator shifted by one continuation byte

	localparam logic [CNT_W-1:0] MAX_WIDTH = 15'd16384;
	localparam logic [7:0] CONT_FLAG = 8'h80;
	localparam logic [6:0] PAYLOAD_MASK = 7'h7f;
	localparam logic [CNT_W-1:0] PAD_LIMIT = 15'd8;

	localparam logic CFG_ROW_WIDTH = 1'b0;
	localparam logic CFG_COLOR_DEPTH = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SHORT_ROW = 2'd1,
		ST_DATA_ENDED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_ROWNUM = 3'b001,
		PH_START = 3'b010,
		PH_CONT = 3'b100
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [CNT_W-1:0] acc;
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0] written;
	} dec_state_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic [CNT_W-1:0] run_count;
		logic row_done;
		status_t row_status;
	} run_result_t;

	function automatic logic [6:0] count_mask(input logic [DEPTH_W-1:0] depth);
		logic [6:0] m;
		case (depth)
			3'd1: m = 7'd63;
			3'd2: m = 7'd31;
			3'd3: m = 7'd15;
			3'd4: m = 7'd7;
			3'd5: m = 7'd3;
			3'd6: m = 7'd1;
			default: m = 7'd0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* hdl/crrd_step.sv */
// Next-state and result logic for one compressed byte of a chart row.
// Depends on crrd_pkg for the state and result structs and the count masks.
`timescale 1ns / 1ps
`default_nettype none

module crrd_step (
	input  var crrd_pkg::dec_state_t          cur,
	input  wire [7:0]                         data_byte,
	input  wire                               end_of_data,
	input  wire [crrd_pkg::CNT_W-1:0]         row_width,
	input  wire [crrd_pkg::DEPTH_W-1:0]       color_depth,
	output crrd_pkg::dec_state_t              nxt,
	output logic                              res_valid,
	output crrd_pkg::run_result_t             res
);

	logic [crrd_pkg::CNT_W-1:0] width;
	logic [crrd_pkg::CNT_W-1:0] left;
	logic [crrd_pkg::ACC_EXT_W-1:0] acc_ext;
	logic [crrd_pkg::CNT_W-1:0] acc_cont;
	logic [6:0] start_bits;
	logic [crrd_pkg::CNT_W-1:0] acc_start;
	logic [crrd_pkg::COLOR_W-1:0] color_start;
	logic [2:0] color_shift;
	logic [crrd_pkg::CNT_W-1:0] run_acc;
	logic [crrd_pkg::CNT_W:0] run_len;
	logic [crrd_pkg::CNT_W-1:0] run_capped;
	logic [crrd_pkg::CNT_W-1:0] missing;
	logic [crrd_pkg::COLOR_W-1:0] res_color;

	assign width = (row_width > crrd_pkg::MAX_WIDTH) ? crrd_pkg::MAX_WIDTH : row_width;
	assign left = (cur.written < width) ? (width - cur.written) : '0;
	assign missing = width - cur.written;

	// continuation byte: shift in seven more count bits, saturate at the width
	assign acc_ext = {cur.acc, 7'd0} + {{crrd_pkg::CNT_W{1'b0}}, data_byte[6:0]};
	assign acc_cont = (acc_ext > {7'd0, width}) ? width : acc_ext[crrd_pkg::CNT_W-1:0];

	// run-start byte: colour in the top bits, count below
	assign color_shift = 3'd7 - color_depth;
	assign color_start = (data_byte[6:0] & crrd_pkg::PAYLOAD_MASK) >> color_shift;
	assign start_bits = data_byte[6:0] & crrd_pkg::count_mask(color_depth);
	assign acc_start = ({8'd0, start_bits} > width) ? width : {8'd0, start_bits};

	assign run_acc = (cur.phase == crrd_pkg::PH_CONT) ? acc_cont : acc_start;
	assign run_len = {1'b0, run_acc} + 16'd1;
	assign run_capped = (run_len > {1'b0, left}) ? left : run_len[crrd_pkg::CNT_W-1:0];

	always_comb begin
		nxt = cur;
		res_valid = 1'b0;
		res_color = cur.color;
		res.run_count = '0;
		res.row_done = 1'b0;
		res.row_status = crrd_pkg::ST_OK;
		if (end_of_data) begin
			res_valid = 1'b1;
			res.row_done = 1'b1;
			res.row_status = crrd_pkg::ST_DATA_ENDED;
			nxt.phase = crrd_pkg::PH_ROWNUM;
			nxt.acc = '0;
			nxt.color = 7'd1;
			nxt.written = '0;
		end else begin
			case (cur.phase)
				crrd_pkg::PH_ROWNUM: begin
					if (!data_byte[7]) begin
						nxt.phase = crrd_pkg::PH_START;
					end
				end
				crrd_pkg::PH_CONT: begin
					nxt.acc = acc_cont;
					if (!data_byte[7]) begin
						res_valid = 1'b1;
						res.run_count = run_capped;
						nxt.written = cur.written + run_capped;
						nxt.acc = '0;
						nxt.phase = crrd_pkg::PH_START;
					end
				end
				crrd_pkg::PH_START: begin
					if (data_byte == 8'd0) begin
						// end of row: pad a nearly full row, flag a short one
						res_valid = 1'b1;
						res.row_done = 1'b1;
						if (cur.written < width) begin
							if (missing < crrd_pkg::PAD_LIMIT) begin
								res.run_count = missing;
							end else begin
								res.row_status = crrd_pkg::ST_SHORT_ROW;
							end
						end
						nxt.phase = crrd_pkg::PH_ROWNUM;
						nxt.acc = '0;
						nxt.color = 7'd1;
						nxt.written = '0;
					end else begin
						nxt.color = color_start;
						res_color = color_start;
						nxt.acc = acc_start;
						if ((data_byte & crrd_pkg::CONT_FLAG) != 8'd0) begin
							nxt.phase = crrd_pkg::PH_CONT;
						end else begin
							res_valid = 1'b1;
							res.run_count = run_capped;
							nxt.written = cur.written + run_capped;
							nxt.acc = '0;
						end
					end
				end
				default: begin
					nxt.phase = crrd_pkg::PH_ROWNUM;
				end
			endcase
		end
		res.pixel_value = {1'b0, res_color} - 8'd1;
	end

endmodule

`default_nettype wire

/* hdl/chart_row_rle_decoder_unit.sv */
// Top level of the chart row run-length decoder: input register, state, result register.
// Depends on crrd_pkg and crrd_step.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake         | Payload
// s_axis    | in  | tvalid / tready   | tdata = data_byte, tuser = end_of_data
// m_axis    | out | tvalid / tready   | tdata = pixel_value, run_count; tlast = row_done;
//           |     |                   | tuser = row_status
// cfg       | in  | valid / ready     | index 0 row_width, 1 color_depth
//
// One byte per cycle unless m_axis stalls: a byte is held in the input register,
// and its result is registered in the output register when the byte advances.
// The per-byte work is shifts, masks, one 22-bit add and compare, and narrower adds, subtracts and compares.
// The input register advances whenever the byte makes no result or the output
// register is free or being taken; a stall at m_axis holds both registers only
// while the byte in the input register has a result to hand on.
// Reset puts the decoder in row-number skipping with both registers empty.

module chart_row_rle_decoder_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire        s_axis_tuser,   // [0] end_of_data
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] pixel_value, [22:8] run_count, [23] zero
	output logic       m_axis_tlast,   // row_done
	output logic [1:0] m_axis_tuser,   // [1:0] row_status
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        cfg_index,
	input  wire [14:0] cfg_data
);

	logic s1_valid;
	logic [7:0] data_byte_s1;
	logic end_of_data_s1;

	logic [crrd_pkg::CNT_W-1:0] row_width_q;
	logic [crrd_pkg::DEPTH_W-1:0] color_depth_q;
	crrd_pkg::dec_state_t state_q;
	crrd_pkg::dec_state_t state_nxt;

	logic res_valid;
	crrd_pkg::run_result_t res;
	logic out_valid_q;
	crrd_pkg::run_result_t out_q;

	logic out_free;
	logic s1_fire;
	logic s_accept;

	crrd_step u_step (
		.cur         (state_q),
		.data_byte   (data_byte_s1),
		.end_of_data (end_of_data_s1),
		.row_width   (row_width_q),
		.color_depth (color_depth_q),
		.nxt         (state_nxt),
		.res_valid   (res_valid),
		.res         (res)
	);

	assign out_free = !out_valid_q || m_axis_tready;
	assign s1_fire = s1_valid && (!res_valid || out_free);
	assign s_axis_tready = !s1_valid || s1_fire;
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= 15'd1;
			color_depth_q <= 3'd7;
		end else if (cfg_valid) begin
			case (cfg_index)
				crrd_pkg::CFG_ROW_WIDTH: row_width_q <= cfg_data;
				crrd_pkg::CFG_COLOR_DEPTH: color_depth_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			data_byte_s1 <= s_axis_tdata;
			end_of_data_s1 <= s_axis_tuser;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= crrd_pkg::PH_ROWNUM;
			state_q.acc <= '0;
			state_q.color <= 7'd1;
			state_q.written <= '0;
		end else if (s1_fire) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_fire && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_q.run_count, out_q.pixel_value};
	assign m_axis_tlast = out_q.row_done;
	assign m_axis_tuser = out_q.row_status;

endmodule

`default_nettype wire
